// ===== hdl/idnat_pkg.sv =====
package idnat_pkg;

  localparam int unsigned NodeW = 7;
  localparam int unsigned IdW   = 128;

  localparam logic [NodeW-1:0] NodeIdMax = 7'd127;

  localparam logic OpFind  = 1'b0;
  localparam logic OpStore = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] vendor_id;
    logic [31:0] product_code;
    logic [31:0] revision_number;
    logic [31:0] serial_number;
    logic [7:0]  requested_node;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [NodeW-1:0] found_node;
    logic [NodeW-1:0] entry_count;
  } rsp_t;

  // One table entry as held in the RAM: the full identity and its node id.
  typedef struct packed {
    logic [IdW-1:0]   identity;
    logic [NodeW-1:0] node;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic id_eq;
    logic node_ok;
    logic node_eq;
  } cmp_t;

endpackage

// ===== hdl/identity_node_id_assignment_table.sv =====
// Channel   | Ports                 | Transfer
// ----------+-----------------------+-------------------------------------------
// request   | start, busy, req_i    | edge with start high and busy low
// result    | done_o, rsp_o         | done_o high for one cycle, always taken
//
// A request scans the stored entries one per cycle through a single RAM read
// port and one shared identity comparator; a find hit or a store conflict ends the scan early.
// busy stays high from the transfer until the result is presented.
// Reset empties the table; entry contents are never cleared.
// The receiver cannot stall the result.
module identity_node_id_assignment_table #(
  parameter int unsigned TABLE_ENTRIES = 127
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  idnat_pkg::req_t req_i,
  output logic            busy,
  output logic            done_o,
  output idnat_pkg::rsp_t rsp_o
);
  import idnat_pkg::*;

  localparam int unsigned AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  logic [AddrW-1:0] match_q, match_d;
  logic             have_match_q, have_match_d;
  logic             conflict_q, conflict_d;
  logic             found_q, found_d;
  logic [NodeW-1:0] found_node_q, found_node_d;
  logic             done_q, done_d;
  req_t             req_q, req_d;
  rsp_t             rsp_q, rsp_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata, ram_rdata;
  cmp_t             cmp;

  logic             hit, more, node_valid, store_ok;

  idnat_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  idnat_cmp u_cmp (
    .entry_i (ram_rdata),
    .req_i   (req_q),
    .cmp_o   (cmp)
  );

  assign more       = (idx_q < count_q);
  assign node_valid = (req_q.requested_node != '0) && !req_q.requested_node[7];
  assign store_ok   = node_valid && !conflict_q &&
                      (have_match_q || (count_q < CntW'(TABLE_ENTRIES)));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    match_d      = match_q;
    have_match_d = have_match_q;
    conflict_d   = conflict_q;
    found_d      = found_q;
    found_node_d = found_node_q;
    req_d        = req_q;
    rsp_d        = rsp_q;
    done_d       = 1'b0;
    hit          = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = have_match_q ? match_q : count_q[AddrW-1:0];
    ram_wdata.identity = {req_q.vendor_id, req_q.product_code,
                          req_q.revision_number, req_q.serial_number};
    ram_wdata.node     = req_q.requested_node[NodeW-1:0];

    case (state_q)
      StIdle: begin
        if (start) begin
          req_d        = req_i;
          idx_d        = '0;
          pend_d       = 1'b0;
          have_match_d = 1'b0;
          conflict_d   = 1'b0;
          found_d      = 1'b0;
          found_node_d = '0;
          // A store with an out-of-range node id needs no scan.
          if (req_i.opcode == OpStore &&
              (req_i.requested_node == '0 || req_i.requested_node[7])) begin
            state_d = StFinish;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // The entry read in the previous cycle is judged while the next is read.
        if (pend_q) begin
          if (req_q.opcode == OpFind) begin
            if (cmp.id_eq && cmp.node_ok) begin
              found_d      = 1'b1;
              found_node_d = ram_rdata.node;
              hit          = 1'b1;
            end
          end else begin
            if (cmp.id_eq) begin
              match_d      = pidx_q;
              have_match_d = 1'b1;
            end else if (cmp.node_eq) begin
              conflict_d = 1'b1;
              hit        = 1'b1;
            end
          end
        end
        if (!hit && more) begin
          ram_re = 1'b1;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q[AddrW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (hit || (!pend_q && !more)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (req_q.opcode == OpFind) begin
          rsp_d.success    = found_q;
          rsp_d.found_node = found_node_q;
          rsp_d.entry_count = NodeW'(count_q);
        end else begin
          rsp_d.success    = store_ok;
          rsp_d.found_node = '0;
          ram_we           = store_ok;
          if (store_ok && !have_match_q) begin
            count_d = count_q + 1'b1;
            rsp_d.entry_count = NodeW'(count_q + 1'b1);
          end else begin
            rsp_d.entry_count = NodeW'(count_q);
          end
        end
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      have_match_q <= 1'b0;
      conflict_q   <= 1'b0;
      found_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      have_match_q <= have_match_d;
      conflict_q   <= conflict_d;
      found_q      <= found_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    match_q      <= match_d;
    found_node_q <= found_node_d;
    req_q        <= req_d;
    rsp_q        <= rsp_d;
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== hdl/idnat_ram.sv =====
module idnat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/idnat_cmp.sv =====
module idnat_cmp (
  input  idnat_pkg::entry_t entry_i,
  input  idnat_pkg::req_t   req_i,
  output idnat_pkg::cmp_t   cmp_o
);
  import idnat_pkg::*;

  logic [IdW-1:0] req_id;

  assign req_id = {req_i.vendor_id, req_i.product_code,
                   req_i.revision_number, req_i.serial_number};

  // Node ids never exceed the maximum in seven bits, so only zero is out of range.
  assign cmp_o.id_eq   = (entry_i.identity == req_id);
  assign cmp_o.node_ok = (entry_i.node != '0) && (entry_i.node <= NodeIdMax);
  assign cmp_o.node_eq = ({1'b0, entry_i.node} == req_i.requested_node);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import idnat_pkg::*;

  localparam int unsigned TableEntries = 127;
  localparam int unsigned PoolSize     = 48;
  localparam int unsigned StallLimit   = 4000;

  // Tracks the expected contents of the identity table and the responses that
  // the accepted requests should produce, oldest first.
  class assignment_table_sb;
    logic [IdW-1:0]   id_store   [TableEntries];
    logic [NodeW-1:0] node_store [TableEntries];
    int unsigned      used;
    rsp_t             expected_responses [$];
    int unsigned      errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void note_request(req_t r);
      logic [IdW-1:0] key;
      rsp_t           resp;
      logic           conflict;
      logic           hit;
      int unsigned    match_idx;
      key       = {r.vendor_id, r.product_code, r.revision_number, r.serial_number};
      resp      = '0;
      conflict  = 1'b0;
      hit       = 1'b0;
      match_idx = 0;
      if (r.opcode == OpFind) begin
        for (int unsigned i = 0; i < used; i++) begin
          if (id_store[i] == key && node_store[i] != '0) begin
            resp.success    = 1'b1;
            resp.found_node = node_store[i];
            break;
          end
        end
      end else if (r.requested_node >= 8'd1 && r.requested_node <= {1'b0, NodeIdMax}) begin
        for (int unsigned i = 0; i < used; i++) begin
          if (id_store[i] == key) begin
            hit       = 1'b1;
            match_idx = i;
          end else if ({1'b0, node_store[i]} == r.requested_node) begin
            conflict = 1'b1;
            break;
          end
        end
        if (!conflict) begin
          if (hit) begin
            node_store[match_idx] = r.requested_node[NodeW-1:0];
            resp.success          = 1'b1;
          end else if (used < TableEntries) begin
            id_store[used]   = key;
            node_store[used] = r.requested_node[NodeW-1:0];
            used++;
            resp.success     = 1'b1;
          end
        end
      end
      resp.entry_count = used[NodeW-1:0];
      expected_responses.push_back(resp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_responses.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0d, actual %0d", want.success, got.success);
        errors++;
      end
      if (got.found_node !== want.found_node) begin
        $error("found_node: expected %0d, actual %0d", want.found_node, got.found_node);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    function int unsigned count();
      return used;
    endfunction

    function logic [IdW-1:0] stored_identity(int unsigned idx);
      return id_store[idx];
    endfunction

    function logic [NodeW-1:0] stored_node(int unsigned idx);
      return node_store[idx];
    endfunction

    // A node id that no entry holds yet, searched from a random starting point.
    function int unsigned free_node();
      int unsigned cand;
      logic        taken;
      cand = $urandom_range(127, 1);
      for (int unsigned k = 0; k < 127; k++) begin
        taken = 1'b0;
        for (int unsigned i = 0; i < used; i++) begin
          if (node_store[i] == cand[NodeW-1:0]) taken = 1'b1;
        end
        if (!taken) return cand;
        cand = (cand == 127) ? 1 : cand + 1;
      end
      return 0;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  assignment_table_sb sb;
  int unsigned        idle_pct;
  int unsigned        stall_cycles;

  identity_node_id_assignment_table #(
    .TABLE_ENTRIES(TableEntries)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .req_i (req_i),
    .busy  (busy),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic req_t make_req(logic op, logic [IdW-1:0] id, logic [7:0] node);
    req_t r;
    r.opcode          = op;
    r.vendor_id       = id[127:96];
    r.product_code    = id[95:64];
    r.revision_number = id[63:32];
    r.serial_number   = id[31:0];
    r.requested_node  = node;
    return r;
  endfunction

  function automatic logic [IdW-1:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [IdW-1:0] flip_bit(logic [IdW-1:0] id);
    return id ^ (128'd1 << $urandom_range(127, 0));
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  // Holds start high until the block takes the request; an idle burst may come first.
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99, 0) < idle_pct) gap = $urandom_range(7, 1);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_response(rsp_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [IdW-1:0] pool [PoolSize];
    logic [IdW-1:0] ones_id;
    logic [IdW-1:0] zero_id;
    logic [IdW-1:0] id_a;
    logic [IdW-1:0] id;
    int unsigned    roll;
    int unsigned    node;
    int unsigned    idx;
    sb           = new();
    idle_pct     = 0;
    stall_cycles = 0;
    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ones_id = '1;
    zero_id = '0;
    id_a    = {32'hFFFF_FFFF, 96'd0};

    // Directed: empty table, invalid node ids, conflicts, updates and near misses.
    send_request(make_req(OpFind, zero_id, 8'd0));
    send_request(make_req(OpStore, zero_id, 8'd0));
    send_request(make_req(OpStore, zero_id, 8'd128));
    send_request(make_req(OpStore, zero_id, 8'd255));
    send_request(make_req(OpStore, ones_id, 8'd127));
    send_request(make_req(OpStore, zero_id, 8'd1));
    send_request(make_req(OpFind, ones_id, 8'd0));
    send_request(make_req(OpFind, zero_id, 8'hFF));
    send_request(make_req(OpStore, id_a, 8'd1));
    send_request(make_req(OpStore, id_a, 8'd127));
    send_request(make_req(OpStore, ones_id, 8'd5));
    send_request(make_req(OpFind, ones_id, 8'd5));
    send_request(make_req(OpStore, ones_id, 8'd1));
    send_request(make_req(OpStore, zero_id, 8'd1));
    send_request(make_req(OpFind, {ones_id[127:1], 1'b0}, 8'd0));
    send_request(make_req(OpFind, {1'b0, ones_id[126:0]}, 8'd0));
    send_request(make_req(OpStore, id_a, 8'd2));
    send_request(make_req(OpFind, id_a, 8'hAA));

    // Pool of identities in which many differ from a neighbour by a single bit.
    for (int unsigned i = 0; i < PoolSize; i++) begin
      pool[i] = (i % 3 == 0) ? rand_id() : flip_bit(pool[i-1]);
    end

    // Mixed finds and stores over the pool, including invalid node ids.
    for (int unsigned n = 0; n < 230; n++) begin
      if (n % 32 == 0) idle_pct = pick_idle();
      roll = $urandom_range(99, 0);
      id   = pool[$urandom_range(PoolSize - 1, 0)];
      if (roll < 45) begin
        if ($urandom_range(99, 0) < 85) node = $urandom_range(127, 1);
        else if ($urandom_range(1, 0) == 1) node = 0;
        else node = $urandom_range(255, 128);
        send_request(make_req(OpStore, id, 8'(node)));
      end else if (roll < 85) begin
        send_request(make_req(OpFind, id, 8'($urandom)));
      end else if (roll < 95) begin
        send_request(make_req(OpFind, rand_id(), 8'($urandom)));
      end else begin
        send_request(make_req(OpStore, rand_id(), 8'($urandom)));
      end
    end

    // Fill the table with fresh identities on free node ids.
    idle_pct = 20;
    while (sb.count() < TableEntries) begin
      send_request(make_req(OpStore, rand_id(), 8'(sb.free_node())));
      if ($urandom_range(99, 0) < 30) begin
        idx = $urandom_range(sb.count() - 1, 0);
        send_request(make_req(OpFind, sb.stored_identity(idx), 8'($urandom)));
      end
    end

    // Full table: hits, near misses, self updates and conflicting stores.
    for (int unsigned n = 0; n < 180; n++) begin
      if (n % 32 == 0) idle_pct = pick_idle();
      if (n >= 120) idle_pct = 0;
      roll = $urandom_range(99, 0);
      idx  = $urandom_range(sb.count() - 1, 0);
      id   = sb.stored_identity(idx);
      if (roll < 40) begin
        send_request(make_req(OpFind, id, 8'($urandom)));
      end else if (roll < 50) begin
        send_request(make_req(OpFind, flip_bit(id), 8'($urandom)));
      end else if (roll < 65) begin
        send_request(make_req(OpStore, id, {1'b0, sb.stored_node(idx)}));
      end else if (roll < 75) begin
        send_request(make_req(OpStore, id, 8'($urandom_range(127, 1))));
      end else if (roll < 90) begin
        send_request(make_req(OpStore, rand_id(), 8'($urandom)));
      end else begin
        send_request(make_req(OpStore, id, ($urandom_range(1, 0) == 1) ? 8'd0 : 8'($urandom_range(255, 128))));
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TableEntries + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
